// ----- sv/range_max_sparse_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Range max sparse table unit: assertion macros
// Immediate-consequence and next-cycle property checks, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SPARSE_TABLE_UNIT_DEFINES_SVH
`define RANGE_MAX_SPARSE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RMST_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmst: same-cycle check failed");
`define RMST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmst: next-cycle check failed");
`else
`define RMST_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RMST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- sv/rmst_pkg.sv -----
// ----------------------------------------------------------------------------
// Range max sparse table package
// Sizes, operation and status codes, result type and helper functions.
// ----------------------------------------------------------------------------
package rmst_pkg;

   localparam int DEPTH       = 1024;
   localparam int LEVELS      = 11;
   localparam int VALUE_WIDTH = 48;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int ADDR_W = LVL_W + IDX_W;
   localparam int WORDS  = LEVELS * DEPTH;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_QUERY  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_BEYOND = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPEND,
      ST_QUERY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] max_value;
      status_type                    status;
      logic [CNT_W-1:0]              stored_count;
   } rsp_type;

   function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
      logic [LVL_W-1:0] k;
      k = '0;
      for (int b = 1; b < CNT_W; b++) begin
         if (v[b]) begin
            k = LVL_W'(b);
         end
      end
      if (k > LVL_W'(LEVELS - 1)) begin
         k = LVL_W'(LEVELS - 1);
      end
      return k;
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] smax(
      input logic signed [VALUE_WIDTH-1:0] a,
      input logic signed [VALUE_WIDTH-1:0] b);
      return (a >= b) ? a : b;
   endfunction

endpackage

// ----- sv/range_max_sparse_table_unit.sv -----
// ----------------------------------------------------------------------------
// Range max sparse table unit
// Clear, append and range-maximum query over a sparse table held in RAM.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  func, element_value,
//                                               range_left, range_right
//   rsp_      out        rsp_valid / rsp_ready  max_value, status, stored_count
//
// Clear, rejected and unused requests go from idle straight to finish; a query
// reads two table words and takes their maximum. An append writes level 0 first,
// then does one read-modify-write of the RAM per level ending at the new index.
// Reset zeroes the count; table contents stay undefined, no clearing pass.
// A result waits in the engine while the output register is held; the next
// request is taken once the engine is back in idle.
// ----------------------------------------------------------------------------
`include "range_max_sparse_table_unit_defines.svh"

module range_max_sparse_table_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_func,
   input  logic signed [rmst_pkg::VALUE_WIDTH-1:0] req_element_value,
   input  logic [rmst_pkg::IDX_W-1:0]              req_range_left,
   input  logic [rmst_pkg::IDX_W-1:0]              req_range_right,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [rmst_pkg::VALUE_WIDTH-1:0] rsp_max_value,
   output logic [1:0]                              rsp_status,
   output logic [rmst_pkg::CNT_W-1:0]              rsp_stored_count
);

   import rmst_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    out_free;
   logic    done;
   rsp_type result;

   rmst_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_element_value (req_element_value),
      .req_range_left    (req_range_left),
      .req_range_right   (req_range_right),
      .out_free          (out_free),
      .done              (done),
      .result            (result)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_value    = rsp_data_ff.max_value;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_stored_count = rsp_data_ff.stored_count;

   `RMST_ASSERT_IMPLIES(a_done_slot_free, clock, reset, done, out_free)
   `RMST_ASSERT_IMPLIES(a_count_bound, clock, reset, rsp_valid, rsp_stored_count <= CNT_W'(DEPTH))
   `RMST_ASSERT_IMPLIES(a_fail_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_max_value == '0)
   `RMST_ASSERT_NEXT(a_clear_count, clock, reset, req_valid && req_ready && req_func == FUNC_CLEAR, result.stored_count == '0)

endmodule

// ----- sv/rmst_ram.sv -----
// ----------------------------------------------------------------------------
// Range max sparse table RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rmst_ram #(
   parameter  int WORDS  = 2,
   parameter  int DATA_W = 8,
   localparam int ADDR_W = $clog2(WORDS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [DATA_W-1:0] rd_a_data,
   output logic [DATA_W-1:0] rd_b_data
);

   logic [DATA_W-1:0] mem_ff [WORDS];
   logic [DATA_W-1:0] rd_a_data_ff;
   logic [DATA_W-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_data_ff <= mem_ff[rd_a_addr];
      rd_b_data_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

// ----- sv/rmst_engine.sv -----
// ----------------------------------------------------------------------------
// Range max sparse table engine
// Sequencer for clear, append (one read-modify-write per level) and query.
// ----------------------------------------------------------------------------
module rmst_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_func,
   input  logic signed [rmst_pkg::VALUE_WIDTH-1:0] req_element_value,
   input  logic [rmst_pkg::IDX_W-1:0]            req_range_left,
   input  logic [rmst_pkg::IDX_W-1:0]            req_range_right,
   input  logic                                  out_free,
   output logic                                  done,
   output rmst_pkg::rsp_type                     result
);

   import rmst_pkg::*;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              n_ff, n_in;
   logic [LVL_W-1:0]              lvl_ff, lvl_in;
   logic signed [VALUE_WIDTH-1:0] cur_ff, cur_in;
   rsp_type                       res_ff, res_in;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [VALUE_WIDTH-1:0]        wr_data;
   logic [ADDR_W-1:0]             rd_a_addr;
   logic [ADDR_W-1:0]             rd_b_addr;
   logic [VALUE_WIDTH-1:0]        rd_a_data;
   logic [VALUE_WIDTH-1:0]        rd_b_data;

   logic                          idle;
   logic                          full;
   logic                          q_empty;
   logic                          q_beyond;
   logic [CNT_W-1:0]              q_len;
   logic [LVL_W-1:0]              q_k;
   logic [CNT_W-1:0]              q_span;
   logic [IDX_W-1:0]              q_b_idx;
   logic [CNT_W-1:0]              n_plus1;
   logic [LVL_W:0]                next_lvl;
   logic                          more;
   logic signed [VALUE_WIDTH-1:0] merged;
   logic [IDX_W-1:0]              wr_idx;
   logic [IDX_W-1:0]              rd_idx_next;

   rmst_ram #(
      .WORDS  (WORDS),
      .DATA_W (VALUE_WIDTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign idle      = (state_ff == ST_IDLE);
   assign req_ready = idle;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign q_empty   = (req_range_left > req_range_right);
   assign q_beyond  = (CNT_W'(req_range_right) >= count_ff);
   assign q_len     = CNT_W'(req_range_right) - CNT_W'(req_range_left) + CNT_W'(1);
   assign q_k       = floor_log2(q_len);
   assign q_span    = CNT_W'(1) << q_k;
   assign q_b_idx   = IDX_W'(CNT_W'(req_range_right) + CNT_W'(1) - q_span);

   assign n_plus1     = n_ff + CNT_W'(1);
   assign next_lvl    = {1'b0, lvl_ff} + (LVL_W + 1)'(1);
   assign more        = (next_lvl < (LVL_W + 1)'(LEVELS)) && ((n_plus1 >> next_lvl) != '0);
   assign merged      = smax($signed(rd_a_data), cur_ff);
   assign wr_idx      = IDX_W'(n_plus1 - (CNT_W'(1) << lvl_ff));
   assign rd_idx_next = IDX_W'(n_plus1 - (CNT_W'(1) << next_lvl));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  FUNC_APPEND: begin
                     state_in = (!full && count_ff != '0) ? ST_APPEND : ST_FINISH;
                  end
                  FUNC_QUERY: begin
                     state_in = (!q_empty && !q_beyond) ? ST_QUERY : ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_APPEND: begin
            state_in = more ? ST_APPEND : ST_FINISH;
         end
         ST_QUERY: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = out_free ? ST_IDLE : ST_FINISH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = cur_ff;
      rd_a_addr = '0;
      rd_b_addr = '0;
      count_in  = count_ff;
      n_in      = n_ff;
      lvl_in    = lvl_ff;
      cur_in    = cur_ff;
      res_in    = res_ff;
      done      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in.max_value    = '0;
               res_in.status       = STATUS_OK;
               res_in.stored_count = count_ff;
               case (req_func)
                  FUNC_CLEAR: begin
                     count_in            = '0;
                     res_in.stored_count = '0;
                  end
                  FUNC_APPEND: begin
                     if (full) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = {LVL_W'(0), count_ff[IDX_W-1:0]};
                        wr_data   = req_element_value;
                        rd_a_addr = {LVL_W'(0), IDX_W'(count_ff - CNT_W'(1))};
                        cur_in    = req_element_value;
                        n_in      = count_ff;
                        lvl_in    = LVL_W'(1);
                        if (count_ff == '0) begin
                           count_in            = CNT_W'(1);
                           res_in.stored_count = CNT_W'(1);
                        end
                     end
                  end
                  FUNC_QUERY: begin
                     if (q_empty) begin
                        res_in.status = STATUS_EMPTY;
                     end else if (q_beyond) begin
                        res_in.status = STATUS_BEYOND;
                     end else begin
                        rd_a_addr = {q_k, req_range_left};
                        rd_b_addr = {q_k, q_b_idx};
                     end
                  end
                  default: begin
                     res_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_APPEND: begin
            wr_en     = 1'b1;
            wr_addr   = {lvl_ff, wr_idx};
            wr_data   = merged;
            cur_in    = merged;
            rd_a_addr = {lvl_ff, rd_idx_next};
            lvl_in    = next_lvl[LVL_W-1:0];
            if (!more) begin
               count_in            = n_plus1;
               res_in.max_value    = '0;
               res_in.status       = STATUS_OK;
               res_in.stored_count = n_plus1;
            end
         end
         ST_QUERY: begin
            res_in.max_value    = smax($signed(rd_a_data), $signed(rd_b_data));
            res_in.status       = STATUS_OK;
            res_in.stored_count = count_ff;
         end
         ST_FINISH: begin
            done = out_free;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      lvl_ff <= lvl_in;
      cur_ff <= cur_in;
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule
